FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on a clock, active through reset
`define ASSERT_AT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// concurrent assertion sampled on a clock, off while reset is low
`define ASSERT_AT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/wpp_pkg.sv
// shared types, constants and helpers for the word pair proximity scanner
package wpp_pkg;

    // default sizes
    localparam int MAX_WORD_LEN_DEF  = 8;
    localparam int MAX_DOC_CHARS_DEF = 65536;

    // fixed field widths
    localparam int CH_W      = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_CFG_W = 4;
    localparam int DIST_W    = 18;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_WORD,
        CFG_FIRST_LEN,
        CFG_SECOND_WORD,
        CFG_SECOND_LEN
    } t_cfg_idx;

    // character codes
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_PERIOD  = 8'h2E;
    localparam logic [CH_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CH_W-1:0] CASE_STEP  = 8'h20;

    // word close events handed from front to back
    typedef struct packed {
        logic close_a;       // a delimiter closed the running word
        logic hit_a_first;
        logic hit_a_second;
        logic last;          // last character: close the trailing word and report
        logic hit_b_first;
        logic hit_b_second;
    } t_close_ctl;

    // fold a-z onto A-Z, other bytes unchanged
    function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_STEP : c;
    endfunction

    // word delimiters
    function automatic logic is_delim(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_PERIOD) || (c == CH_COMMA);
    endfunction

endpackage

FILE: rtl/core/word_pair_proximity_scanner.sv
// top level of the word pair proximity scanner
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      i_ch, i_is_final
//  result    out        o_valid / i_stall      o_found, o_distance_x2
//  config    in         i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// one character per cycle is accepted while o_stall is low; the front classifies it in that cycle
// a result is registered: the last character's event goes into the queue, and the back
// pops it into its result register once that register does not hold a stalled result
// o_stall rises only when the event queue is full, i.e. the result side is stalled
// reset is synchronous, active low; it clears scan state and sets targets to word 0,
// length 1, with no clearing pass
module word_pair_proximity_scanner #(
    parameter int MAX_WORD_LEN  = wpp_pkg::MAX_WORD_LEN_DEF,
    parameter int MAX_DOC_CHARS = wpp_pkg::MAX_DOC_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [wpp_pkg::CH_W-1:0]      i_ch,
    input  logic                          i_is_final,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [wpp_pkg::DIST_W-1:0]    o_distance_x2,
    input  logic                          i_cfg_wr_en,
    input  logic [wpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wpp_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int MID_W   = $clog2(2 * MAX_DOC_CHARS + 1);
    localparam int CTL_W   = $bits(wpp_pkg::t_close_ctl);
    localparam int ENTRY_W = CTL_W + 3 * MID_W;

    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    wpp_pkg::t_close_ctl  f_ctl;
    wpp_pkg::t_close_ctl  q_ctl;
    logic [MID_W-1:0]     f_mid_a, f_mid_b, f_len_x2;
    logic [MID_W-1:0]     q_mid_a, q_mid_b, q_len_x2;
    logic [ENTRY_W-1:0]   q_in;
    logic [ENTRY_W-1:0]   q_out;

    // character intake and word close detection
    wpp_front #(
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .MAX_DOC_CHARS (MAX_DOC_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_ch        (i_ch),
        .i_is_final  (i_is_final),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_ctl       (f_ctl),
        .o_mid_a     (f_mid_a),
        .o_mid_b     (f_mid_b),
        .o_len_x2    (f_len_x2)
    );

    // event packing
    assign q_in     = {f_ctl, f_mid_a, f_mid_b, f_len_x2};
    assign q_ctl    = wpp_pkg::t_close_ctl'(q_out[ENTRY_W-1 -: CTL_W]);
    assign q_mid_a  = q_out[3*MID_W-1 -: MID_W];
    assign q_mid_b  = q_out[2*MID_W-1 -: MID_W];
    assign q_len_x2 = q_out[MID_W-1:0];

    wpp_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // distance tracking and result output
    wpp_back #(
        .MAX_DOC_CHARS (MAX_DOC_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_ctl         (q_ctl),
        .i_mid_a       (q_mid_a),
        .i_mid_b       (q_mid_b),
        .i_len_x2      (q_len_x2),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_distance_x2 (o_distance_x2)
    );

endmodule

FILE: rtl/core/wpp_front.sv
// front end: config registers, character classification and word close events
module wpp_front #(
    parameter int MAX_WORD_LEN  = wpp_pkg::MAX_WORD_LEN_DEF,
    parameter int MAX_DOC_CHARS = wpp_pkg::MAX_DOC_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [wpp_pkg::CH_W-1:0]      i_ch,
    input  logic                          i_is_final,
    input  logic                          i_cfg_wr_en,
    input  logic [wpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wpp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output wpp_pkg::t_close_ctl           o_ctl,
    output logic [$clog2(2*MAX_DOC_CHARS+1)-1:0] o_mid_a,
    output logic [$clog2(2*MAX_DOC_CHARS+1)-1:0] o_mid_b,
    output logic [$clog2(2*MAX_DOC_CHARS+1)-1:0] o_len_x2
);

    localparam int POS_W = $clog2(MAX_DOC_CHARS + 1);
    localparam int MID_W = $clog2(2 * MAX_DOC_CHARS + 1);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);
    localparam int LCW   = wpp_pkg::LEN_CFG_W;
    localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_DOC_CHARS);
    localparam logic [MID_W-1:0] MID_CAP     = MID_W'(2 * MAX_DOC_CHARS);
    localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(MAX_WORD_LEN);
    localparam logic [LEN_W-1:0] LEN_OVER    = LEN_W'(MAX_WORD_LEN + 1);
    localparam logic [LCW-1:0]   LEN_CFG_MAX = LCW'(MAX_WORD_LEN);

    logic [wpp_pkg::CFG_W-1:0] r_first_word;
    logic [wpp_pkg::CFG_W-1:0] r_second_word;
    logic [LCW-1:0]            r_first_len;
    logic [LCW-1:0]            r_second_len;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_start;
    logic [LEN_W-1:0] r_len;
    logic             r_m1;
    logic             r_m2;

    logic [POS_W-1:0] n_start;
    logic [LEN_W-1:0] n_len;
    logic             n_m1;
    logic             n_m2;

    logic             accept;
    logic             delim;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_next;
    logic [2:0]       byte_idx;
    logic [wpp_pkg::CH_W-1:0] fc;
    logic [wpp_pkg::CH_W-1:0] tb_first;
    logic [wpp_pkg::CH_W-1:0] tb_second;

    // doubled midpoint 2*start+len, capped at twice the document limit
    function automatic logic [MID_W-1:0] mid_x2(input logic [POS_W-1:0] s,
                                                input logic [LEN_W-1:0] n);
        logic [MID_W:0] sum;
        sum = (MID_W+1)'({s, 1'b0}) + (MID_W+1)'(n);
        return (sum > {1'b0, MID_CAP}) ? MID_CAP : sum[MID_W-1:0];
    endfunction

    // closed word matches a target of this length
    function automatic logic len_hit(input logic m, input logic [LEN_W-1:0] n,
                                     input logic [LCW-1:0] cfg_len);
        return m && (LCW'(n) == cfg_len) && (cfg_len <= LEN_CFG_MAX);
    endfunction

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign delim   = wpp_pkg::is_delim(i_ch);

    // saturating next position
    assign pos_inc  = (POS_W+1)'(r_pos) + (POS_W+1)'(1);
    assign pos_next = (pos_inc > {1'b0, POS_MAX}) ? POS_MAX : pos_inc[POS_W-1:0];

    // target bytes at the running word offset
    assign byte_idx  = 3'(r_len);
    assign fc        = wpp_pkg::fold_case(i_ch);
    assign tb_first  = wpp_pkg::fold_case(r_first_word[{byte_idx, 3'b000} +: 8]);
    assign tb_second = wpp_pkg::fold_case(r_second_word[{byte_idx, 3'b000} +: 8]);

    // running word after this character
    always_comb begin
        n_start = r_start;
        n_len   = r_len;
        n_m1    = r_m1;
        n_m2    = r_m2;
        if (delim) begin
            n_start = pos_next;
            n_len   = '0;
            n_m1    = 1'b1;
            n_m2    = 1'b1;
        end else if (r_len < LEN_MAX) begin
            n_len = r_len + LEN_W'(1);
            n_m1  = r_m1 && (fc == tb_first);
            n_m2  = r_m2 && (fc == tb_second);
        end else begin
            n_len = LEN_OVER;
            n_m1  = 1'b0;
            n_m2  = 1'b0;
        end
    end

    // close events: word ended by a delimiter, and the trailing word on the last character
    always_comb begin
        o_ctl.close_a      = delim;
        o_ctl.hit_a_first  = len_hit(r_m1, r_len, r_first_len);
        o_ctl.hit_a_second = !o_ctl.hit_a_first && len_hit(r_m2, r_len, r_second_len);
        o_ctl.last         = i_is_final;
        o_ctl.hit_b_first  = len_hit(n_m1, n_len, r_first_len);
        o_ctl.hit_b_second = !o_ctl.hit_b_first && len_hit(n_m2, n_len, r_second_len);
    end

    assign o_mid_a  = mid_x2(r_start, r_len);
    assign o_mid_b  = mid_x2(n_start, n_len);
    assign o_len_x2 = MID_W'({pos_next, 1'b0});
    assign o_push   = accept && (delim || i_is_final);

    // config registers and per-document scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_word  <= '0;
            r_second_word <= '0;
            r_first_len   <= LCW'(1);
            r_second_len  <= LCW'(1);
            r_pos         <= '0;
            r_start       <= '0;
            r_len         <= '0;
            r_m1          <= 1'b1;
            r_m2          <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                case (wpp_pkg::t_cfg_idx'(i_cfg_index))
                    wpp_pkg::CFG_FIRST_WORD:  r_first_word  <= i_cfg_data;
                    wpp_pkg::CFG_FIRST_LEN:   r_first_len   <= i_cfg_data[LCW-1:0];
                    wpp_pkg::CFG_SECOND_WORD: r_second_word <= i_cfg_data;
                    wpp_pkg::CFG_SECOND_LEN:  r_second_len  <= i_cfg_data[LCW-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_is_final) begin
                    r_pos   <= '0;
                    r_start <= '0;
                    r_len   <= '0;
                    r_m1    <= 1'b1;
                    r_m2    <= 1'b1;
                end else begin
                    r_pos   <= pos_next;
                    r_start <= n_start;
                    r_len   <= n_len;
                    r_m1    <= n_m1;
                    r_m2    <= n_m2;
                end
            end
        end
    end

endmodule

FILE: rtl/core/wpp_queue.sv
// short queue of word close events between front and back
module wpp_queue #(
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = wpp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/wpp_back.sv
// back end: latest midpoints, running minimum distance and result register
module wpp_back #(
    parameter int MAX_DOC_CHARS = wpp_pkg::MAX_DOC_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  wpp_pkg::t_close_ctl           i_ctl,
    input  logic [$clog2(2*MAX_DOC_CHARS+1)-1:0] i_mid_a,
    input  logic [$clog2(2*MAX_DOC_CHARS+1)-1:0] i_mid_b,
    input  logic [$clog2(2*MAX_DOC_CHARS+1)-1:0] i_len_x2,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [wpp_pkg::DIST_W-1:0]    o_distance_x2
);

    localparam int MID_W = $clog2(2 * MAX_DOC_CHARS + 1);

    logic [MID_W-1:0] r_fmid;
    logic [MID_W-1:0] r_smid;
    logic             r_fseen;
    logic             r_sseen;
    logic [MID_W-1:0] r_best;
    logic             r_out_valid;
    logic             r_found;
    logic [wpp_pkg::DIST_W-1:0] r_dist;

    logic             out_free;
    logic             hit_af;
    logic             hit_as;
    logic [MID_W-1:0] f1, s1, f2, s2;
    logic             fs1, ss1, fs2, ss2;
    logic [MID_W-1:0] d1, d2;
    logic [MID_W-1:0] best1, best2, res;

    function automatic logic [MID_W-1:0] abs_diff(input logic [MID_W-1:0] a,
                                                  input logic [MID_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_empty && (!i_ctl.last || out_free);

    // state after the delimiter-closed word
    assign hit_af = i_ctl.close_a && i_ctl.hit_a_first;
    assign hit_as = i_ctl.close_a && i_ctl.hit_a_second;
    assign f1     = hit_af ? i_mid_a : r_fmid;
    assign s1     = hit_as ? i_mid_a : r_smid;
    assign fs1    = r_fseen || hit_af;
    assign ss1    = r_sseen || hit_as;
    assign d1     = abs_diff(f1, s1);
    assign best1  = (i_ctl.close_a && fs1 && ss1 && (d1 < r_best)) ? d1 : r_best;

    // state after the trailing word of the document
    assign f2    = i_ctl.hit_b_first  ? i_mid_b : f1;
    assign s2    = i_ctl.hit_b_second ? i_mid_b : s1;
    assign fs2   = fs1 || i_ctl.hit_b_first;
    assign ss2   = ss1 || i_ctl.hit_b_second;
    assign d2    = abs_diff(f2, s2);
    assign best2 = (fs2 && ss2 && (d2 < best1)) ? d2 : best1;
    assign res   = (best2 < i_len_x2) ? best2 : i_len_x2;

    // match tracking and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmid      <= '0;
            r_smid      <= '0;
            r_fseen     <= 1'b0;
            r_sseen     <= 1'b0;
            r_best      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_ctl.last) begin
                    r_fmid  <= '0;
                    r_smid  <= '0;
                    r_fseen <= 1'b0;
                    r_sseen <= 1'b0;
                    r_best  <= '1;
                end else begin
                    r_fmid  <= f1;
                    r_smid  <= s1;
                    r_fseen <= fs1;
                    r_sseen <= ss1;
                    r_best  <= best1;
                end
            end
            if (o_pop && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_ctl.last) begin
            r_found <= fs2 && ss2;
            r_dist  <= (fs2 && ss2) ? wpp_pkg::DIST_W'(res) : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_found;
    assign o_distance_x2 = r_dist;

endmodule

FILE: rtl/core/wpp_checker.sv
// port-level checks for the word pair proximity scanner and their bind
`include "assert_macros.svh"

module wpp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_found,
    input logic [wpp_pkg::DIST_W-1:0] o_distance_x2
);

    // stalled result payload
    property p_out_hold;
        o_valid && i_stall |=> o_valid && $stable(o_found) && $stable(o_distance_x2);
    endproperty

    // reset leaves no result pending and the queue not full
    `ASSERT_AT(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "not idle after reset")

    // a stalled result holds
    `ASSERT_AT_RST(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result changed")

    // a miss reports zero distance
    `ASSERT_AT_RST(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found |-> o_distance_x2 == '0, "miss with nonzero distance")

endmodule

bind word_pair_proximity_scanner wpp_checker u_wpp_checker (.*);

FILE: verif/tb.sv
// self-checking testbench for the word pair proximity scanner
`timescale 1ns / 100ps

module tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int WORD_MAX      = 8;
    localparam int DOC_MAX       = 65536;
    localparam logic [17:0] MID_CAP = 18'(2 * DOC_MAX);
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int GAP_CHARS     = 40;
    localparam longint LIMIT_CYCLES = 1_000_000;

    // one document report as the block should show it
    typedef struct packed {
        logic                       found;
        logic [wpp_pkg::DIST_W-1:0] dist_x2;
    } t_report;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [wpp_pkg::CH_W-1:0]        i_ch = '0;
    logic                            i_is_final = 1'b0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_found;
    logic [wpp_pkg::DIST_W-1:0]      o_distance_x2;
    logic                            i_cfg_wr_en = 1'b0;
    logic [wpp_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [wpp_pkg::CFG_W-1:0]       i_cfg_data = '0;

    // traffic shaping knobs
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned stall_hold_req;
    int unsigned hold_left;
    int          items_sent;
    int          errors;
    longint      cycle_count;

    // target registers as the block should hold them
    logic [63:0] tgt_first_word, tgt_second_word;
    logic [3:0]  tgt_first_len, tgt_second_len;

    // running scan state of the current document
    logic [16:0] scan_pos, word_start_pos;
    logic [3:0]  cur_word_len;
    logic        cur_is_first, cur_is_second;
    logic [17:0] first_mid_x2, second_mid_x2;
    logic        first_seen, second_seen;
    logic [17:0] closest_x2;

    t_report expected_reports[$];

    word_pair_proximity_scanner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_is_final    (i_is_final),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_distance_x2 (o_distance_x2),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side stall: random, or a long hold when asked for
    always @(negedge i_clk) begin
        if (stall_hold_req != 0) begin
            hold_left = stall_hold_req;
            stall_hold_req = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each result transfer with the oldest pending report
    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found %0b distance_x2 %0d",
                         $time, o_found, o_distance_x2);
            end else begin
                want = expected_reports.pop_front();
                if (o_found !== want.found) begin
                    errors++;
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, want.found, o_found);
                end
                if (o_distance_x2 !== want.dist_x2) begin
                    errors++;
                    $display("%0t: distance_x2 mismatch, expected %0d actual %0d",
                             $time, want.dist_x2, o_distance_x2);
                end
            end
        end
    end

    // ascii letters fold to upper case, other bytes stay
    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return c == wpp_pkg::CH_SPACE || c == wpp_pkg::CH_PERIOD || c == wpp_pkg::CH_COMMA;
    endfunction

    function automatic logic [16:0] next_pos(input logic [16:0] p);
        return (p >= DOC_MAX) ? 17'(DOC_MAX) : p + 17'd1;
    endfunction

    function automatic void reset_scan();
        scan_pos       = '0;
        word_start_pos = '0;
        cur_word_len   = '0;
        cur_is_first   = 1'b1;
        cur_is_second  = 1'b1;
        first_mid_x2   = '0;
        second_mid_x2  = '0;
        first_seen     = 1'b0;
        second_seen    = 1'b0;
        closest_x2     = '1;
    endfunction

    // end of a word: record a target hit and narrow the closest distance
    function automatic void close_word_pred();
        logic [17:0] mid;
        logic [17:0] gap;
        mid = {word_start_pos, 1'b0} + 18'(cur_word_len);
        if (mid > MID_CAP)
            mid = MID_CAP;
        if (cur_is_first && cur_word_len == tgt_first_len && tgt_first_len <= WORD_MAX) begin
            first_mid_x2 = mid;
            first_seen = 1'b1;
        end else if (cur_is_second && cur_word_len == tgt_second_len &&
                     tgt_second_len <= WORD_MAX) begin
            second_mid_x2 = mid;
            second_seen = 1'b1;
        end
        if (first_seen && second_seen) begin
            gap = (first_mid_x2 > second_mid_x2) ? first_mid_x2 - second_mid_x2 :
                                                   second_mid_x2 - first_mid_x2;
            if (gap < closest_x2)
                closest_x2 = gap;
        end
        cur_word_len  = '0;
        cur_is_first  = 1'b1;
        cur_is_second = 1'b1;
    endfunction

    // advance the scan by one accepted character
    function automatic void predict_char(input logic [7:0] c, input logic last_char);
        logic [17:0] len_x2;
        logic [17:0] best;
        logic        both;
        if (is_separator(c)) begin
            close_word_pred();
            word_start_pos = next_pos(scan_pos);
        end else if (cur_word_len < WORD_MAX) begin
            if (upcase(c) != upcase(tgt_first_word[8*cur_word_len +: 8]))
                cur_is_first = 1'b0;
            if (upcase(c) != upcase(tgt_second_word[8*cur_word_len +: 8]))
                cur_is_second = 1'b0;
            cur_word_len = cur_word_len + 4'd1;
        end else begin
            cur_is_first  = 1'b0;
            cur_is_second = 1'b0;
            cur_word_len  = 4'(WORD_MAX + 1);
        end
        scan_pos = next_pos(scan_pos);
        if (last_char) begin
            close_word_pred();
            len_x2 = {scan_pos, 1'b0};
            best = (closest_x2 < len_x2) ? closest_x2 : len_x2;
            both = first_seen && second_seen;
            expected_reports.push_back('{found: both, dist_x2: both ? best : '0});
            reset_scan();
        end
    endfunction

    function automatic logic [63:0] pack_word(input string s);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < s.len() && k < 8; k++)
            w[8*k +: 8] = s[k];
        return w;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'($urandom_range(65, 90));
        if ($urandom_range(1))
            c = c | 8'h20;
        return c;
    endfunction

    // letters flip case at random; other bytes rarely get a near-miss twin
    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (is_letter(c)) begin
            if ($urandom_range(1))
                return c ^ 8'h20;
        end else if ($urandom_range(99) < 5 && !is_separator(c ^ 8'h20)) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // append the text of a target word, letters in random case
    function automatic void add_target_text(ref logic [7:0] doc[$], input logic [63:0] w,
                                            input int len);
        for (int k = 0; k < len; k++)
            doc.push_back(vary_case(k < 8 ? w[8*k +: 8] : rand_letter()));
    endfunction

    // random target with a bias to the extremes of length and byte value
    function automatic void pick_target(output logic [63:0] w, output logic [3:0] len);
        int         mode;
        logic [7:0] c;
        w = {$urandom, $urandom};
        mode = $urandom_range(99);
        if (mode < 10)
            len = $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
        else if (mode < 30)
            len = $urandom_range(1) ? 4'd1 : 4'd8;
        else
            len = 4'($urandom_range(1, 8));
        mode = $urandom_range(99);
        for (int k = 0; k < 8; k++) begin
            if (k < len) begin
                if (mode < 8) begin
                    c = 8'hFF;
                end else if (mode < 14) begin
                    c = 8'h00;
                end else if (mode < 24) begin
                    c = 8'($urandom_range(255));
                    if (is_separator(c))
                        c = 8'h7B;
                end else begin
                    c = rand_letter();
                end
                w[8*k +: 8] = c;
            end
        end
    endfunction

    // offer one character and wait for its transfer
    task automatic send_char(input logic [7:0] c, input logic last_char);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_ch       <= c;
        i_is_final <= last_char;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_char(c, last_char);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == s.len() - 1);
    endtask

    // stop offering and wait until every report has come back
    task automatic drain_reports();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input wpp_pkg::t_cfg_idx idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // program both targets; the block must be idle
    task automatic set_targets(input logic [63:0] w1, input logic [3:0] l1,
                               input logic [63:0] w2, input logic [3:0] l2);
        write_reg(wpp_pkg::CFG_FIRST_WORD, w1);
        write_reg(wpp_pkg::CFG_FIRST_LEN, 64'(l1));
        write_reg(wpp_pkg::CFG_SECOND_WORD, w2);
        write_reg(wpp_pkg::CFG_SECOND_LEN, 64'(l2));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tgt_first_word  = w1;
        tgt_first_len   = l1;
        tgt_second_word = w2;
        tgt_second_len  = l2;
    endtask

    // one document of target words, near misses, random words and noise
    task automatic send_document(input logic [63:0] w1, input logic [3:0] l1,
                                 input logic [63:0] w2, input logic [3:0] l2);
        logic [7:0] doc[$];
        int         nwords;
        int         pick;
        logic [7:0] seps[3];
        seps = '{wpp_pkg::CH_SPACE, wpp_pkg::CH_PERIOD, wpp_pkg::CH_COMMA};
        nwords = $urandom_range(1, 7);
        for (int w = 0; w < nwords; w++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                add_target_text(doc, w1, l1);
            end else if (pick < 60) begin
                add_target_text(doc, w2, l2);
            end else if (pick < 72) begin
                // near miss: one character short or long, or the last one swapped
                if ($urandom_range(1)) begin
                    add_target_text(doc, w1, (l1 > 1 && $urandom_range(1)) ? l1 - 1 : l1 + 1);
                end else begin
                    add_target_text(doc, w2, l2);
                    if (doc.size() != 0)
                        doc[doc.size() - 1] = rand_letter();
                end
            end else if (pick < 88) begin
                repeat ($urandom_range(0, 10)) doc.push_back(rand_letter());
            end else begin
                repeat ($urandom_range(1, 4)) doc.push_back(8'($urandom_range(255)));
            end
            if (w < nwords - 1 || $urandom_range(3) == 0) begin
                doc.push_back(seps[$urandom_range(2)]);
                if ($urandom_range(99) < 20)
                    doc.push_back(seps[$urandom_range(2)]);
            end
        end
        if (doc.size() == 0)
            doc.push_back(seps[$urandom_range(2)]);
        foreach (doc[k])
            send_char(doc[k], k == doc.size() - 1);
    endtask

    // defaults, case folding, trailing separator, same target twice,
    // zero and oversized target lengths, overlong words
    task automatic test_directed_cases();
        send_char(8'hFF, 1'b0);
        send_char(wpp_pkg::CH_SPACE, 1'b0);
        send_char(8'h00, 1'b1);
        drain_reports();
        set_targets(pack_word("CAT"), 4'd3, pack_word("dog"), 4'd3);
        send_text("cat,DOG.");
        drain_reports();
        set_targets(pack_word("ab"), 4'd2, pack_word("AB"), 4'd2);
        send_text("ab AB");
        drain_reports();
        set_targets(pack_word("zz"), 4'd0, pack_word("ZZZZZZZZ"), 4'd15);
        send_text(",zzzzzzzzz");
        drain_reports();
    endtask

    // a long run of empty words between the two targets
    task automatic test_long_document();
        send_idle_pct = 0;
        set_targets(pack_word("A"), 4'd1, pack_word("B"), 4'd1);
        send_char("a", 1'b0);
        repeat (GAP_CHARS) send_char(wpp_pkg::CH_SPACE, 1'b0);
        send_char("b", 1'b1);
        drain_reports();
    endtask

    // result side held off for a long stretch while characters keep coming
    task automatic test_input_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_targets(pack_word("to"), 4'd2, pack_word("be"), 4'd2);
        @(posedge i_clk);
        stall_hold_req = HOLD_CYCLES;
        repeat (3) send_text("to be, or not to be");
        drain_reports();
    endtask

    // random targets and documents under one idle pattern
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int          start_count;
        logic [63:0] w1, w2;
        logic [3:0]  l1, l2;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            drain_reports();
            pick_target(w1, l1);
            if ($urandom_range(99) < 15) begin
                w2 = w1;
                l2 = l1;
            end else begin
                pick_target(w2, l2);
            end
            set_targets(w1, l1, w2, l2);
            repeat ($urandom_range(2, 4)) send_document(w1, l1, w2, l2);
        end
    endtask

    initial begin
        send_idle_pct  = 30;
        recv_stall_pct = 48;
        stall_hold_req = 0;
        hold_left      = 0;
        items_sent     = 0;
        errors         = 0;
        cycle_count    = 0;
        tgt_first_word  = '0;
        tgt_second_word = '0;
        tgt_first_len   = 4'd1;
        tgt_second_len  = 4'd1;
        reset_scan();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_long_document();
        test_input_backpressure();
        test_random_traffic(30, 48, 150);
        test_random_traffic(48, 30, 150);
        test_random_traffic(0, 0, 150);
        drain_reports();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
